// ----- src/qp_mapping_hash_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the queue-pair mapping table
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef QP_MAPPING_HASH_TABLE_UNIT_ASSERT_SVH
`define QP_MAPPING_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define QMHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qmht: same-cycle check failed");

// next-cycle implication
`define QMHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qmht: next-cycle check failed");

`endif

// ----- src/qmht_pkg.sv -----
// ----------------------------------------------------------------------------
// qmht_pkg
// Types, command and status codes, and defaults for the queue-pair mapping table.
// ----------------------------------------------------------------------------
`default_nettype none

package qmht_pkg;

   // field widths fixed by the interface
   localparam int unsigned IP_W  = 32;
   localparam int unsigned QP_W  = 24;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned ST_W  = 2;

   // parameter defaults
   localparam int unsigned BUCKETS_DEF = 1024;
   localparam int unsigned WAYS_DEF    = 4;
   localparam int unsigned QP_BITS_DEF = 24;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_MISS = 2'd1;
   localparam logic [ST_W-1:0] ST_DUP  = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL = 2'd3;

   // request item
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IP_W-1:0]  src_ip;
      logic [IP_W-1:0]  dst_ip;
      logic [QP_W-1:0]  src_qp;
      logic [QP_W-1:0]  dst_qp;
   } req_type;

   // response item
   typedef struct packed {
      logic [ST_W-1:0] status;
      logic [QP_W-1:0] mapped_qp;
      logic            hit_in_reverse;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_VREAD,
      S_VLATCH,
      S_EREAD,
      S_ECMP,
      S_WRITE
   } state_type;

endpackage

`default_nettype wire

// ----- src/qmht_ram.sv -----
// ----------------------------------------------------------------------------
// qmht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qmht_ram #(
   parameter  int unsigned WIDTH = 8,
   parameter  int unsigned DEPTH = 16,
   localparam int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/qmht_cmp.sv -----
// ----------------------------------------------------------------------------
// qmht_cmp
// Shared key compare unit: matches one stored entry against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module qmht_cmp #(
   parameter  int unsigned KQ_W  = 24,
   localparam int unsigned ENT_W = 2 * qmht_pkg::IP_W + 2 * KQ_W
) (
   input  wire logic [ENT_W-1:0]         entry,
   input  wire logic                     way_valid,
   input  wire logic [qmht_pkg::IP_W-1:0] key_a,
   input  wire logic [qmht_pkg::IP_W-1:0] key_b,
   input  wire logic [KQ_W-1:0]          key_qp,
   output logic                          hit,
   output logic      [KQ_W-1:0]          value
);

   import qmht_pkg::*;

   // entry layout, high to low: ip_a, ip_b, key_qp, value
   logic [IP_W-1:0] ent_a;
   logic [IP_W-1:0] ent_b;
   logic [KQ_W-1:0] ent_qp;

   assign ent_a  = entry[ENT_W-1 -: IP_W];
   assign ent_b  = entry[ENT_W-IP_W-1 -: IP_W];
   assign ent_qp = entry[2*KQ_W-1 -: KQ_W];
   assign value  = entry[KQ_W-1:0];

   // full key match, gated by the way's valid bit
   assign hit = way_valid && (ent_a == key_a) && (ent_b == key_b) && (ent_qp == key_qp);

endmodule

`default_nettype wire

// ----- src/qp_mapping_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// qp_mapping_hash_table_unit
// Queue-pair mapping table: forward and reverse set-associative hash tables.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low; req_item carries
//   cmd, both IPs and both queue pairs. busy stays high until the answer is
//   out. One answer per command appears on rsp_item for exactly one cycle,
//   marked by rsp_strobe; the receiver cannot stall it. The next command may
//   be taken in the same cycle the answer is shown.
//   A sequencer walks the ways of a bucket through one shared key comparator,
//   forward table first, then reverse; each way takes an entry RAM read,
//   then a compare. The walk stops at the first match. An add that finds no
//   match and a free way in both tables writes both tables in a write state.
//   The bucket index is the low log2(BUCKETS) bits of (src xor dst) + qp, so
//   BUCKETS must be a power of two; the block does not check it.
//   Reset starts a sweep that zeroes the valid RAMs, one bucket per cycle,
//   with busy high; the clear command runs the same sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "qp_mapping_hash_table_unit_assert.svh"

module qp_mapping_hash_table_unit #(
   parameter int unsigned BUCKETS = qmht_pkg::BUCKETS_DEF,
   parameter int unsigned WAYS    = qmht_pkg::WAYS_DEF,
   parameter int unsigned QP_BITS = qmht_pkg::QP_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire qmht_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output qmht_pkg::rsp_type      rsp_item
);

   import qmht_pkg::*;

   localparam int unsigned BKT_W  = $clog2(BUCKETS);
   localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned KQ_W   = (QP_BITS < QP_W) ? QP_BITS : QP_W;
   localparam int unsigned ENT_W  = 2 * IP_W + 2 * KQ_W;
   localparam int unsigned EDEPTH = BUCKETS * (2 ** WAY_W);
   localparam int unsigned EA_W   = BKT_W + WAY_W;

   // sequencer and control state
   state_type         state_ff,     state_in;
   logic [BKT_W-1:0]  clr_addr_ff,  clr_addr_in;
   logic              clr_rsp_ff,   clr_rsp_in;
   logic              phase_ff,     phase_in;
   logic [WAY_W-1:0]  way_ff,       way_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [CMD_W-1:0]  cmd_ff,    cmd_in;
   logic [IP_W-1:0]   src_ip_ff, src_ip_in;
   logic [IP_W-1:0]   dst_ip_ff, dst_ip_in;
   logic [KQ_W-1:0]   sqp_ff,    sqp_in;
   logic [KQ_W-1:0]   dqp_ff,    dqp_in;
   logic [BKT_W-1:0]  bkt0_ff,   bkt0_in;
   logic [BKT_W-1:0]  bkt1_ff,   bkt1_in;
   logic [WAYS-1:0]   fv_ff,     fv_in;
   logic [WAYS-1:0]   rv_ff,     rv_in;
   rsp_type           rsp_ff,    rsp_in;

   // datapath
   logic [BKT_W-1:0]  ip_x;
   logic [BKT_W-1:0]  hash_f;
   logic [BKT_W-1:0]  hash_r;
   logic              use_rev_key;
   logic [IP_W-1:0]   key_a;
   logic [IP_W-1:0]   key_b;
   logic [KQ_W-1:0]   key_qp;
   logic [ENT_W-1:0]  cmp_entry;
   logic              cmp_valid;
   logic              cmp_hit;
   logic [KQ_W-1:0]   cmp_value;
   logic [WAY_W-1:0]  fw_free;
   logic [WAY_W-1:0]  rw_free;
   logic              last_way;
   logic              rsp_fail;
   logic              rsp_blank;

   // memory ports
   logic              v_wr_en;
   logic [BKT_W-1:0]  fv_wr_addr;
   logic [BKT_W-1:0]  rv_wr_addr;
   logic [WAYS-1:0]   fv_wr_data;
   logic [WAYS-1:0]   rv_wr_data;
   logic [WAYS-1:0]   fv_rd_data;
   logic [WAYS-1:0]   rv_rd_data;
   logic              e_wr_en;
   logic [ENT_W-1:0]  fe_wr_data;
   logic [ENT_W-1:0]  re_wr_data;
   logic [ENT_W-1:0]  fe_rd_data;
   logic [ENT_W-1:0]  re_rd_data;

   // bucket hash: only the low index bits of the 32-bit sum are needed
   assign ip_x   = src_ip_ff[BKT_W-1:0] ^ dst_ip_ff[BKT_W-1:0];
   assign hash_f = ip_x + BKT_W'(dqp_ff);
   assign hash_r = ip_x + BKT_W'(sqp_ff);

   // add searches the reverse table with the swapped key; lookup keeps it
   assign use_rev_key = phase_ff && (cmd_ff == CMD_ADD);
   assign key_a  = use_rev_key ? dst_ip_ff : src_ip_ff;
   assign key_b  = use_rev_key ? src_ip_ff : dst_ip_ff;
   assign key_qp = use_rev_key ? sqp_ff    : dqp_ff;

   assign cmp_entry = phase_ff ? re_rd_data : fe_rd_data;
   assign cmp_valid = phase_ff ? rv_ff[way_ff] : fv_ff[way_ff];
   assign last_way  = (way_ff == WAY_W'(WAYS - 1));

   // lowest free way of each bucket
   always_comb begin
      fw_free = '0;
      rw_free = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!fv_ff[i]) begin
            fw_free = WAY_W'(i);
         end
         if (!rv_ff[i]) begin
            rw_free = WAY_W'(i);
         end
      end
   end

   // memory write data
   assign fv_wr_addr = (state_ff == S_CLEAR) ? clr_addr_ff : bkt0_ff;
   assign rv_wr_addr = (state_ff == S_CLEAR) ? clr_addr_ff : bkt1_ff;
   assign fv_wr_data = (state_ff == S_CLEAR) ? '0 : (fv_ff | (WAYS'(1) << fw_free));
   assign rv_wr_data = (state_ff == S_CLEAR) ? '0 : (rv_ff | (WAYS'(1) << rw_free));
   assign fe_wr_data = {src_ip_ff, dst_ip_ff, dqp_ff, sqp_ff};
   assign re_wr_data = {dst_ip_ff, src_ip_ff, sqp_ff, dqp_ff};

   // valid rows, one per bucket
   qmht_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_fwd_valid (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (fv_wr_addr),
      .wr_data (fv_wr_data),
      .rd_addr (bkt0_ff),
      .rd_data (fv_rd_data)
   );

   qmht_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_rev_valid (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (rv_wr_addr),
      .wr_data (rv_wr_data),
      .rd_addr (bkt1_ff),
      .rd_data (rv_rd_data)
   );

   // entries, addressed by {bucket, way}
   qmht_ram #(.WIDTH(ENT_W), .DEPTH(EDEPTH)) u_fwd_entry (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (EA_W'({bkt0_ff, fw_free})),
      .wr_data (fe_wr_data),
      .rd_addr (EA_W'({bkt0_ff, way_ff})),
      .rd_data (fe_rd_data)
   );

   qmht_ram #(.WIDTH(ENT_W), .DEPTH(EDEPTH)) u_rev_entry (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (EA_W'({bkt1_ff, rw_free})),
      .wr_data (re_wr_data),
      .rd_addr (EA_W'({bkt1_ff, way_ff})),
      .rd_data (re_rd_data)
   );

   // shared compare unit
   qmht_cmp #(.KQ_W(KQ_W)) u_cmp (
      .entry     (cmp_entry),
      .way_valid (cmp_valid),
      .key_a     (key_a),
      .key_b     (key_b),
      .key_qp    (key_qp),
      .hit       (cmp_hit),
      .value     (cmp_value)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         clr_rsp_ff    <= 1'b0;
         phase_ff      <= 1'b0;
         way_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_rsp_ff    <= clr_rsp_in;
         phase_ff      <= phase_in;
         way_ff        <= way_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      src_ip_ff <= src_ip_in;
      dst_ip_ff <= dst_ip_in;
      sqp_ff    <= sqp_in;
      dqp_ff    <= dqp_in;
      bkt0_ff   <= bkt0_in;
      bkt1_ff   <= bkt1_in;
      fv_ff     <= fv_in;
      rv_ff     <= rv_in;
      rsp_ff    <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      phase_in      = phase_ff;
      way_in        = way_ff;
      rsp_strobe_in = 1'b0;
      cmd_in        = cmd_ff;
      src_ip_in     = src_ip_ff;
      dst_ip_in     = dst_ip_ff;
      sqp_in        = sqp_ff;
      dqp_in        = dqp_ff;
      bkt0_in       = bkt0_ff;
      bkt1_in       = bkt1_ff;
      fv_in         = fv_ff;
      rv_in         = rv_ff;
      rsp_in        = rsp_ff;
      v_wr_en       = 1'b0;
      e_wr_en       = 1'b0;

      unique case (state_ff)
         // zero the valid rows one bucket per cycle
         S_CLEAR: begin
            v_wr_en = 1'b1;
            if (clr_addr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_in.status         = ST_OK;
                  rsp_in.mapped_qp      = '0;
                  rsp_in.hit_in_reverse = 1'b0;
               end
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         // take a command transfer
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_item.cmd;
               src_ip_in = req_item.src_ip;
               dst_ip_in = req_item.dst_ip;
               sqp_in    = req_item.src_qp[KQ_W-1:0];
               dqp_in    = req_item.dst_qp[KQ_W-1:0];
               state_in  = S_HASH;
            end
         end

         // bucket indexes and dispatch
         S_HASH: begin
            bkt0_in  = hash_f;
            bkt1_in  = (cmd_ff == CMD_ADD) ? hash_r : hash_f;
            phase_in = 1'b0;
            way_in   = '0;
            if ((cmd_ff == CMD_ADD) || (cmd_ff == CMD_LOOKUP)) begin
               state_in = S_VREAD;
            end else if (cmd_ff == CMD_CLEAR) begin
               clr_addr_in = '0;
               clr_rsp_in  = 1'b1;
               state_in    = S_CLEAR;
            end else begin
               // unused code: no change, plain ok
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.mapped_qp      = '0;
               rsp_in.hit_in_reverse = 1'b0;
               state_in              = S_IDLE;
            end
         end

         // valid rows are being read
         S_VREAD: begin
            state_in = S_VLATCH;
         end

         S_VLATCH: begin
            fv_in    = fv_rd_data;
            rv_in    = rv_rd_data;
            state_in = S_EREAD;
         end

         // entry RAMs are being read at {bucket, way}
         S_EREAD: begin
            state_in = S_ECMP;
         end

         // compare one way, then step the walk
         S_ECMP: begin
            if (cmp_hit) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (cmd_ff == CMD_ADD) begin
                  rsp_in.status         = ST_DUP;
                  rsp_in.mapped_qp      = '0;
                  rsp_in.hit_in_reverse = 1'b0;
               end else begin
                  rsp_in.status         = ST_OK;
                  rsp_in.mapped_qp      = QP_W'(cmp_value);
                  rsp_in.hit_in_reverse = phase_ff;
               end
            end else if (!last_way) begin
               way_in   = way_ff + 1'b1;
               state_in = S_EREAD;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               way_in   = '0;
               state_in = S_EREAD;
            end else if (cmd_ff == CMD_LOOKUP) begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = ST_MISS;
               rsp_in.mapped_qp      = '0;
               rsp_in.hit_in_reverse = 1'b0;
               state_in              = S_IDLE;
            end else if ((&fv_ff) || (&rv_ff)) begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = ST_FULL;
               rsp_in.mapped_qp      = '0;
               rsp_in.hit_in_reverse = 1'b0;
               state_in              = S_IDLE;
            end else begin
               state_in = S_WRITE;
            end
         end

         // store both keys and mark their ways valid
         S_WRITE: begin
            v_wr_en               = 1'b1;
            e_wr_en               = 1'b1;
            rsp_strobe_in         = 1'b1;
            rsp_in.status         = ST_OK;
            rsp_in.mapped_qp      = '0;
            rsp_in.hit_in_reverse = 1'b0;
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   assign rsp_fail  = rsp_strobe && (rsp_item.status != ST_OK);
   assign rsp_blank = (rsp_item.mapped_qp == '0) && !rsp_item.hit_in_reverse;

   `QMHT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `QMHT_ASSERT_IMP(a_rsp_after_work, clock, reset, rsp_strobe, $past(busy))
   `QMHT_ASSERT_IMP(a_nohit_zero, clock, reset, rsp_fail, rsp_blank)

endmodule

`default_nettype wire
